>>> hdl/dprq_pkg.sv
// ----------------------------------------------------------------------------
// dprq_pkg: shared types and constants for the dynamic priority ready queue
// Holds the queue geometry, field widths, event codes, and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package dprq_pkg;

	// Queue geometry.
	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Field widths.
	localparam int TAG_W     = 8;
	localparam int IN_PRIO_W = 9;
	localparam int PRIO_W    = 10;
	localparam int TIME_W    = 8;
	localparam int EVENT_W   = 3;

	// Lowest priority that a task can age down to.
	localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};

	// Request kinds.
	localparam logic REQ_ADMIT    = 1'b0;
	localparam logic REQ_DISPATCH = 1'b1;

	// Result event codes.
	typedef enum logic [EVENT_W-1:0] {
		EV_ADMIT   = 3'd0,
		EV_REJECT  = 3'd1,
		EV_REQUEUE = 3'd2,
		EV_FINISH  = 3'd3,
		EV_IDLE    = 3'd4
	} event_t;

	// Queue operations issued by the controller.
	typedef enum logic [1:0] {
		OP_NONE    = 2'd0,
		OP_ADMIT   = 2'd1,
		OP_REQUEUE = 2'd2,
		OP_FINISH  = 2'd3
	} op_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;
		logic exec;
		op_t  op;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic req_dispatch;
		logic empty;
		logic full;
		logic need_zero;
		logic head_finish;
	} stat_t;

endpackage

>>> hdl/dprq_ctrl.sv
// ----------------------------------------------------------------------------
// dprq_ctrl: request sequencer
// Two-state controller. It captures a request, then decides the event from
// the datapath status, issues the queue operation and strobes the result.
// ----------------------------------------------------------------------------
module dprq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  dprq_pkg::stat_t stat,
	output dprq_pkg::cmd_t  cmd,
	output logic            busy,
	output logic            strobe,
	output logic [dprq_pkg::EVENT_W-1:0] event_code
);
	import dprq_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   strobe_q;
	event_t event_q;
	event_t next_event;
	op_t    next_op;

	// Decide the event and the queue operation from the captured request.
	always_comb begin
		next_event = EV_IDLE;
		next_op    = OP_NONE;
		if (stat.req_dispatch == REQ_ADMIT) begin
			if (stat.full || stat.need_zero) begin
				next_event = EV_REJECT;
			end else begin
				next_event = EV_ADMIT;
				next_op    = OP_ADMIT;
			end
		end else if (stat.empty) begin
			next_event = EV_IDLE;
		end else if (stat.head_finish) begin
			next_event = EV_FINISH;
			next_op    = OP_FINISH;
		end else begin
			next_event = EV_REQUEUE;
			next_op    = OP_REQUEUE;
		end
	end

	// Commands to the datapath.
	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && start;
		cmd.exec    = (state_q == ST_EXEC);
		cmd.op      = next_op;
	end

	// State and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			busy_q   <= 1'b0;
			strobe_q <= 1'b0;
			event_q  <= EV_ADMIT;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
						busy_q  <= 1'b1;
					end
				end
				ST_EXEC: begin
					state_q  <= ST_IDLE;
					busy_q   <= 1'b0;
					strobe_q <= 1'b1;
					event_q  <= next_event;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy       = busy_q;
	assign strobe     = strobe_q;
	assign event_code = event_q;

`ifndef SYNTHESIS
	// Every accepted request raises busy, and busy ends with a result transfer.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");
	a_busy_one: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy && strobe)
		else $error("busy cycle not followed by a result transfer");
	// A result transfer only follows a busy cycle.
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result transfer without a worked request");
`endif

endmodule

>>> hdl/dprq_dp.sv
// ----------------------------------------------------------------------------
// dprq_dp: ready queue datapath
// Request capture registers, a sorted shift-register queue with one compare
// per cell, and the result registers. A pop and a reinsert share one cycle.
// ----------------------------------------------------------------------------
module dprq_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  dprq_pkg::cmd_t cmd,
	input  logic           req_type,
	input  logic [dprq_pkg::TAG_W-1:0]            task_tag,
	input  logic signed [dprq_pkg::IN_PRIO_W-1:0] start_priority,
	input  logic [dprq_pkg::TIME_W-1:0]           need_time,
	output dprq_pkg::stat_t stat,
	output logic [dprq_pkg::TAG_W-1:0]         ran_tag,
	output logic signed [dprq_pkg::PRIO_W-1:0] ran_priority,
	output logic [dprq_pkg::TIME_W-1:0]        ran_time_done,
	output logic [dprq_pkg::CNT_W-1:0]         queue_count
);
	import dprq_pkg::*;

	// Captured request.
	logic                     req_type_q;
	logic [TAG_W-1:0]         req_tag_q;
	logic signed [PRIO_W-1:0] req_prio_q;
	logic [TIME_W-1:0]        req_need_q;

	// Queue cells, head at index zero.
	logic [TAG_W-1:0]         entry_tag_q      [QUEUE_DEPTH];
	logic signed [PRIO_W-1:0] entry_priority_q [QUEUE_DEPTH];
	logic [TIME_W-1:0]        entry_need_q     [QUEUE_DEPTH];
	logic [TIME_W-1:0]        entry_done_q     [QUEUE_DEPTH];
	logic [CNT_W-1:0]         occupancy_q;

	// Result registers.
	logic [TAG_W-1:0]         ran_tag_q;
	logic signed [PRIO_W-1:0] ran_priority_q;
	logic [TIME_W-1:0]        ran_done_q;
	logic [CNT_W-1:0]         count_q;

	// Working signals.
	logic                     shift;
	logic                     ins_en;
	logic                     q_write;
	logic [CNT_W-1:0]         src_occ;
	logic [CNT_W-1:0]         next_occ;
	logic [TIME_W-1:0]        head_done_inc;
	logic signed [PRIO_W-1:0] aged_prio;
	logic [TAG_W-1:0]         ins_tag;
	logic signed [PRIO_W-1:0] ins_prio;
	logic [TIME_W-1:0]        ins_need;
	logic [TIME_W-1:0]        ins_done;
	logic [TAG_W-1:0]         src_tag  [QUEUE_DEPTH];
	logic signed [PRIO_W-1:0] src_prio [QUEUE_DEPTH];
	logic [TIME_W-1:0]        src_need [QUEUE_DEPTH];
	logic [TIME_W-1:0]        src_done [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]   keep;
	logic [QUEUE_DEPTH-1:0]   at_pos;

	// Capture the request when it is accepted.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_type_q <= req_type;
			req_tag_q  <= task_tag;
			req_prio_q <= PRIO_W'(start_priority);
			req_need_q <= need_time;
		end
	end

	// Head task bookkeeping and aging with saturation at the minimum.
	assign head_done_inc = entry_done_q[0] + TIME_W'(1);
	assign aged_prio     = (entry_priority_q[0] == PRIO_MIN) ? PRIO_MIN
	                     : entry_priority_q[0] - PRIO_W'(1);

	// Status toward the controller.
	always_comb begin
		stat.req_dispatch = req_type_q;
		stat.empty        = (occupancy_q == '0);
		stat.full         = (occupancy_q == CNT_W'(QUEUE_DEPTH));
		stat.need_zero    = (req_need_q == '0);
		stat.head_finish  = (head_done_inc == entry_need_q[0]);
	end

	// Operation decode: dispatch ops pop the head first.
	always_comb begin
		shift   = (cmd.op == OP_REQUEUE) || (cmd.op == OP_FINISH);
		ins_en  = (cmd.op == OP_ADMIT) || (cmd.op == OP_REQUEUE);
		q_write = cmd.exec && (cmd.op != OP_NONE);
		src_occ = shift ? occupancy_q - CNT_W'(1) : occupancy_q;
		case (cmd.op)
			OP_ADMIT:   next_occ = occupancy_q + CNT_W'(1);
			OP_FINISH:  next_occ = occupancy_q - CNT_W'(1);
			default:    next_occ = occupancy_q;
		endcase
		if (cmd.op == OP_REQUEUE) begin
			ins_tag  = entry_tag_q[0];
			ins_prio = aged_prio;
			ins_need = entry_need_q[0];
			ins_done = head_done_inc;
		end else begin
			ins_tag  = req_tag_q;
			ins_prio = req_prio_q;
			ins_need = req_need_q;
			ins_done = '0;
		end
	end

	// Per-cell source, compare and insert position.
	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			localparam int NXT = (gi + 1 < QUEUE_DEPTH) ? gi + 1 : gi;

			// Source view: the queue itself, or the queue with its head removed.
			assign src_tag[gi]  = shift ? entry_tag_q[NXT]      : entry_tag_q[gi];
			assign src_prio[gi] = shift ? entry_priority_q[NXT] : entry_priority_q[gi];
			assign src_need[gi] = shift ? entry_need_q[NXT]     : entry_need_q[gi];
			assign src_done[gi] = shift ? entry_done_q[NXT]     : entry_done_q[gi];

			// A cell keeps its task if it is occupied and not outranked.
			assign keep[gi] = (CNT_W'(gi) < src_occ) && !(ins_prio > src_prio[gi]);

			if (gi == 0) begin : g_head
				assign at_pos[gi] = !keep[gi];
			end else begin : g_body
				assign at_pos[gi] = !keep[gi] && keep[gi-1];
			end

			// Cell update: keep, take the new task, or take the neighbor nearer the head.
			always_ff @(posedge clk) begin
				if (q_write) begin
					if (!ins_en || keep[gi]) begin
						entry_tag_q[gi]      <= src_tag[gi];
						entry_priority_q[gi] <= src_prio[gi];
						entry_need_q[gi]     <= src_need[gi];
						entry_done_q[gi]     <= src_done[gi];
					end else if (at_pos[gi]) begin
						entry_tag_q[gi]      <= ins_tag;
						entry_priority_q[gi] <= ins_prio;
						entry_need_q[gi]     <= ins_need;
						entry_done_q[gi]     <= ins_done;
					end else if (gi > 0) begin
						entry_tag_q[gi]      <= src_tag[(gi > 0) ? gi - 1 : 0];
						entry_priority_q[gi] <= src_prio[(gi > 0) ? gi - 1 : 0];
						entry_need_q[gi]     <= src_need[(gi > 0) ? gi - 1 : 0];
						entry_done_q[gi]     <= src_done[(gi > 0) ? gi - 1 : 0];
					end
				end
			end
		end
	endgenerate

	// Occupancy count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupancy_q <= '0;
		end else if (q_write) begin
			occupancy_q <= next_occ;
		end
	end

	// Result fields; run details only for a dispatched task.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			count_q <= next_occ;
			if (shift) begin
				ran_tag_q      <= entry_tag_q[0];
				ran_priority_q <= entry_priority_q[0];
				ran_done_q     <= head_done_inc;
			end else begin
				ran_tag_q      <= '0;
				ran_priority_q <= '0;
				ran_done_q     <= '0;
			end
		end
	end

	assign ran_tag       = ran_tag_q;
	assign ran_priority  = ran_priority_q;
	assign ran_time_done = ran_done_q;
	assign queue_count   = count_q;

`ifndef SYNTHESIS
	// The occupancy never exceeds the number of cells.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue occupancy above depth");
	// The occupancy only changes on a queue write.
	a_occ_step: assert property (@(posedge clk) disable iff (!arst_n)
		!q_write |=> $stable(occupancy_q))
		else $error("occupancy changed without a queue write");
	// The head always outranks or ties the second task.
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy_q > CNT_W'(1) |-> entry_priority_q[0] >= entry_priority_q[1])
		else $error("queue head out of priority order");
`endif

endmodule

>>> hdl/dynamic_priority_ready_queue.sv
// ----------------------------------------------------------------------------
// dynamic_priority_ready_queue: ready queue with priority aging
// A request is captured in the idle state and worked in the execute state,
// and its result is strobed from the registered outputs; a new request is
// accepted only in the idle state, so none is taken before the last result.
// Reset clears the queue occupancy and the controller; the receiver cannot
// stall, so every result is a transfer on its strobe cycle.
// ----------------------------------------------------------------------------
module dynamic_priority_ready_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic req_type,
	input  logic [dprq_pkg::TAG_W-1:0]            task_tag,
	input  logic signed [dprq_pkg::IN_PRIO_W-1:0] start_priority,
	input  logic [dprq_pkg::TIME_W-1:0]           need_time,
	output logic strobe,
	output logic [dprq_pkg::EVENT_W-1:0]       event_code,
	output logic [dprq_pkg::TAG_W-1:0]         ran_tag,
	output logic signed [dprq_pkg::PRIO_W-1:0] ran_priority,
	output logic [dprq_pkg::TIME_W-1:0]        ran_time_done,
	output logic [dprq_pkg::CNT_W-1:0]         queue_count
);
	import dprq_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Sequencer.
	dprq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.stat       (stat),
		.cmd        (cmd),
		.busy       (busy),
		.strobe     (strobe),
		.event_code (event_code)
	);

	// Queue storage and result fields.
	dprq_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.req_type       (req_type),
		.task_tag       (task_tag),
		.start_priority (start_priority),
		.need_time      (need_time),
		.stat           (stat),
		.ran_tag        (ran_tag),
		.ran_priority   (ran_priority),
		.ran_time_done  (ran_time_done),
		.queue_count    (queue_count)
	);

endmodule
